FILE: rtl/core/sdspi_pkg.sv
package sdspi_pkg;

	localparam int unsigned CmdW    = 6;
	localparam int unsigned ArgW    = 32;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned LimitW  = 16;
	localparam int unsigned OpW     = 2;
	localparam int unsigned FrameW  = 3;
	localparam int unsigned PhaseW  = 2;

	localparam int unsigned InDataW  = 48;
	localparam int unsigned OutDataW = 24;

	localparam logic [LimitW-1:0] BusyLimitReset = 16'd300;

	localparam logic [OpW-1:0] OP_START = 2'd0;
	localparam logic [OpW-1:0] OP_XCHG  = 2'd1;
	localparam logic [OpW-1:0] OP_TICK  = 2'd2;
	localparam logic [OpW-1:0] OP_FLUSH = 2'd3;

	localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
	localparam logic [PhaseW-1:0] PH_BUSY = 2'd1;
	localparam logic [PhaseW-1:0] PH_SEND = 2'd2;
	localparam logic [PhaseW-1:0] PH_RESP = 2'd3;

	localparam logic [ByteW-1:0] IDLE_BYTE  = 8'hFF;
	localparam logic [ByteW-1:0] CMD_PREFIX = 8'h40;
	localparam logic [ByteW-1:0] CRC_CMD0   = 8'h95;
	localparam logic [ByteW-1:0] CRC_CMD8   = 8'h87;
	localparam logic [FrameW-1:0] LAST_FRAME = 3'd5;
	localparam logic [CmdW-1:0] CMD_GO_IDLE = 6'd0;
	localparam logic [CmdW-1:0] CMD_IF_COND = 6'd8;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [FrameW-1:0] frame_index;
		logic [ByteW-1:0]  poll_count;
		logic [LimitW-1:0] elapsed_ms;
		logic [CmdW-1:0]   held_command;
		logic [ArgW-1:0]   held_argument;
		logic              fault;
	} eng_state_t;

	typedef struct packed {
		logic             valid;
		logic             result_kind;
		logic [ByteW-1:0] tx_byte;
		logic [ByteW-1:0] status;
		logic             fault;
	} eng_result_t;

	function automatic logic [ByteW-1:0] frame_byte(
		input logic [CmdW-1:0]   cmd,
		input logic [ArgW-1:0]   arg,
		input logic [FrameW-1:0] k
	);
		logic [ByteW-1:0] b;
		case (k)
			3'd0: b = CMD_PREFIX | {2'b00, cmd};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				if (cmd == CMD_GO_IDLE)
					b = CRC_CMD0;
				else if (cmd == CMD_IF_COND)
					b = CRC_CMD8;
				else
					b = IDLE_BYTE;
			end
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/core/sdspi_step.sv
module sdspi_step (
	input  sdspi_pkg::eng_state_t           st,
	input  logic [sdspi_pkg::OpW-1:0]       op,
	input  logic [sdspi_pkg::CmdW-1:0]      cmd_index,
	input  logic [sdspi_pkg::ArgW-1:0]      argument,
	input  logic [sdspi_pkg::ByteW-1:0]     rx_byte,
	input  logic                            exchange_failed,
	input  logic [sdspi_pkg::LimitW-1:0]    busy_wait_limit_ms,
	output sdspi_pkg::eng_state_t           nxt,
	output sdspi_pkg::eng_result_t          res
);
	import sdspi_pkg::*;

	always_comb begin
		nxt = st;
		res = '0;
		unique case (op)
			OP_FLUSH: begin
				nxt.fault = 1'b0;
			end
			OP_TICK: begin
				if (st.phase == PH_BUSY && st.elapsed_ms != {LimitW{1'b1}})
					nxt.elapsed_ms = st.elapsed_ms + 16'd1;
			end
			OP_START: begin
				if (st.phase == PH_IDLE) begin
					nxt.held_command  = cmd_index;
					nxt.held_argument = argument;
					nxt.frame_index   = '0;
					nxt.poll_count    = '0;
					nxt.elapsed_ms    = '0;
					res.valid = 1'b1;
					if (st.fault) begin
						res.result_kind = 1'b1;
						res.status      = IDLE_BYTE;
					end else begin
						nxt.phase   = PH_BUSY;
						res.tx_byte = IDLE_BYTE;
					end
				end
			end
			OP_XCHG: begin
				if (st.phase != PH_IDLE) begin
					res.valid = 1'b1;
					if (exchange_failed) begin
						nxt.fault       = 1'b1;
						nxt.phase       = PH_IDLE;
						res.result_kind = 1'b1;
						res.status      = IDLE_BYTE;
					end else begin
						unique case (st.phase)
							PH_BUSY: begin
								if (rx_byte != IDLE_BYTE && st.elapsed_ms < busy_wait_limit_ms) begin
									res.tx_byte = IDLE_BYTE;
								end else begin
									nxt.phase       = PH_SEND;
									nxt.frame_index = '0;
									res.tx_byte = frame_byte(st.held_command, st.held_argument,
										3'd0);
								end
							end
							PH_SEND: begin
								if (st.frame_index < LAST_FRAME) begin
									nxt.frame_index = st.frame_index + 3'd1;
									res.tx_byte = frame_byte(st.held_command, st.held_argument,
										st.frame_index + 3'd1);
								end else begin
									nxt.phase      = PH_RESP;
									nxt.poll_count = '0;
									res.tx_byte    = IDLE_BYTE;
								end
							end
							PH_RESP: begin
								if (!rx_byte[ByteW-1] || st.poll_count == {ByteW{1'b1}}) begin
									nxt.phase       = PH_IDLE;
									res.result_kind = 1'b1;
									res.status      = rx_byte;
								end else begin
									nxt.poll_count = st.poll_count + 8'd1;
									res.tx_byte    = IDLE_BYTE;
								end
							end
							default: begin
								res.valid = 1'b0;
							end
						endcase
					end
				end
			end
			default: begin
				nxt = st;
			end
		endcase
		res.fault = nxt.fault;
	end

endmodule

FILE: rtl/core/sd_spi_command_engine_core.sv
// Pipeline: the input register takes the word, then its result is registered into the
// output register that drives m_tvalid; a stalled output holds the input register.
// Throughput: one input word per cycle unless the output stalls; the result and input registers
// advance together, so a stalled output holds at most one pending input word.
// Reset (arst_n low, asynchronous): engine idle, fault clear, counters and held
// command zero, busy limit 300 ms, both word registers empty.
module sd_spi_command_engine_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sdspi_pkg::LimitW-1:0]          cfg_data,    // busy_wait_limit_ms
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// cmd_index[5:0], argument[37:6], rx_byte[45:38], exchange_failed[46], zero[47]
	input  logic [sdspi_pkg::InDataW-1:0]         s_tdata,
	input  logic [sdspi_pkg::OpW-1:0]             s_tuser,     // opcode[1:0]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// tx_byte[7:0], status[15:8], fault[16], zero[23:17]
	output logic [sdspi_pkg::OutDataW-1:0]        m_tdata,
	output logic                                  m_tuser      // result_kind[0]
);
	import sdspi_pkg::*;

	logic [LimitW-1:0] limit_q;
	eng_state_t        st_q;
	eng_state_t        st_nxt;
	eng_result_t       res;

	logic              valid_s1;
	logic [OpW-1:0]    op_s1;
	logic [CmdW-1:0]   cmd_s1;
	logic [ArgW-1:0]   arg_s1;
	logic [ByteW-1:0]  rx_s1;
	logic              fail_s1;

	logic              out_valid_q;
	logic              out_kind_q;
	logic [ByteW-1:0]  out_tx_q;
	logic [ByteW-1:0]  out_status_q;
	logic              out_fault_q;

	logic              out_free;
	logic              advance;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= BusyLimitReset;
		else if (cfg_valid && cfg_ready)
			limit_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= s_tuser;
			cmd_s1  <= s_tdata[5:0];
			arg_s1  <= s_tdata[37:6];
			rx_s1   <= s_tdata[45:38];
			fail_s1 <= s_tdata[46];
		end
	end

	sdspi_step u_step (
		.st                 (st_q),
		.op                 (op_s1),
		.cmd_index          (cmd_s1),
		.argument           (arg_s1),
		.rx_byte            (rx_s1),
		.exchange_failed    (fail_s1),
		.busy_wait_limit_ms (limit_q),
		.nxt                (st_nxt),
		.res                (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= '0;
		else if (advance)
			st_q <= st_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (m_tready)
				out_valid_q <= 1'b0;
			if (advance && res.valid)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_kind_q   <= res.result_kind;
			out_tx_q     <= res.tx_byte;
			out_status_q <= res.status;
			out_fault_q  <= res.fault;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {7'd0, out_fault_q, out_status_q, out_tx_q};

endmodule
